// ----- sv/pvs_zero_run_decoder_macros.svh -----
// Assertion macros shared by the zero-run visibility decoder modules.
`ifndef PVS_ZERO_RUN_DECODER_MACROS_SVH
`define PVS_ZERO_RUN_DECODER_MACROS_SVH

// Implication checked in the same cycle.
`define PVSZR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvszr assertion failed");

// Implication checked in the next cycle.
`define PVSZR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvszr assertion failed");

`endif

// ----- sv/pvszr_pkg.sv -----
// Package with constants and types of the zero-run visibility decoder.
`timescale 1ns / 1ps

package pvszr_pkg;

    localparam int MAX_LEAVES    = 4096;
    localparam int BITS_PER_BYTE = 8;
    localparam int CMD_DEPTH     = 4;

    localparam int COUNT_W = 13;
    localparam int INDEX_W = 12;

    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] mask;
        logic [INDEX_W-1:0]       base;
        logic                     done;
    } pvszr_cmd_t;

endpackage

// ----- sv/pvs_zero_run_decoder.sv -----
// Top level of the zero-run-length visibility row decoder.
// Each accepted byte is classified by the front end, which keeps the leaf counter, and
// queued as a command; the sequencer then delivers one result beat per cycle while the
// consumer pops: one beat for a zero byte, a run count, a byte past the end of the row or
// a byte with no leaf in range, and otherwise one beat per set bit below the limit, so a
// byte yields one to eight beats. The single result register of the sequencer sets the
// sustained rate; the command queue lets bytes keep arriving while earlier leaves go out.
`timescale 1ns / 1ps

module pvs_zero_run_decoder
    import pvszr_pkg::*;
#(
    parameter int CMD_FIFO_DEPTH = CMD_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         pvs_byte,
    input  logic               row_start,
    output logic               empty,
    input  logic               pop,
    output logic [INDEX_W-1:0] leaf_index,
    output logic               leaf_valid,
    output logic               last,
    output logic               row_done
);

    pvszr_cmd_t new_cmd;
    pvszr_cmd_t head_cmd;
    logic       accept;
    logic       cmd_empty;
    logic       cmd_pop;

    assign accept = push && !full;

    pvszr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .pvs_byte  (pvs_byte),
        .row_start (row_start),
        .cmd       (new_cmd)
    );

    pvszr_cmd_fifo #(
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (new_cmd),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (head_cmd),
        .empty   (cmd_empty)
    );

    pvszr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (head_cmd),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .leaf_index (leaf_index),
        .leaf_valid (leaf_valid),
        .last       (last),
        .row_done   (row_done),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

// ----- sv/pvszr_front.sv -----
// Front end: holds the leaf counter and turns each byte into a leaf mask command.
`timescale 1ns / 1ps

module pvszr_front
    import pvszr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    input  logic               accept,
    input  logic [7:0]         pvs_byte,
    input  logic               row_start,
    output pvszr_cmd_t         cmd
);

    localparam logic [COUNT_W:0] MAX_LIM = (COUNT_W + 1)'(MAX_LEAVES);

    logic [COUNT_W-1:0] leaf_count_reg;
    logic [COUNT_W-1:0] counter_reg;
    logic [COUNT_W-1:0] counter_next;
    logic               pending_reg;
    logic               pending_next;

    logic [COUNT_W:0]       lim;
    logic [COUNT_W:0]       cnt;
    logic                   pend;
    logic [COUNT_W:0]       run_sum;
    logic [COUNT_W:0]       byte_sum;
    logic [COUNT_W:0]       new_cnt;
    logic [BITS_PER_BYTE-1:0] bit_mask;

    always_comb
    begin
        if ({1'b0, leaf_count_reg} > MAX_LIM)
        begin
            lim = MAX_LIM;
        end
        else
        begin
            lim = {1'b0, leaf_count_reg};
        end
        cnt  = row_start ? '0 : {1'b0, counter_reg};
        pend = row_start ? 1'b0 : pending_reg;
        run_sum  = cnt + {3'b000, pvs_byte, 3'b000};
        byte_sum = cnt + (COUNT_W + 1)'(BITS_PER_BYTE);
        for (int i = 0; i < BITS_PER_BYTE; i++)
        begin
            bit_mask[i] = pvs_byte[i] && ((cnt + (COUNT_W + 1)'(i)) < lim);
        end

        new_cnt      = cnt;
        pending_next = pend;
        cmd.mask     = '0;
        cmd.base     = cnt[INDEX_W-1:0];
        if (cnt >= lim)
        begin
            pending_next = 1'b0;
        end
        else if (pend)
        begin
            new_cnt      = (run_sum > lim) ? lim : run_sum;
            pending_next = 1'b0;
        end
        else if (pvs_byte == 8'd0)
        begin
            pending_next = 1'b1;
        end
        else
        begin
            new_cnt  = (byte_sum > lim) ? lim : byte_sum;
            cmd.mask = bit_mask;
        end
        cmd.done     = (new_cnt >= lim);
        counter_next = new_cnt[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg <= '0;
            counter_reg    <= '0;
            pending_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                leaf_count_reg <= cfg_wdata;
            end
            if (accept)
            begin
                counter_reg <= counter_next;
                pending_reg <= pending_next;
            end
        end
    end

endmodule

// ----- sv/pvszr_cmd_fifo.sv -----
// Short command queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module pvszr_cmd_fifo
    import pvszr_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  pvszr_cmd_t wr_data,
    output logic       full,
    input  logic       rd_en,
    output pvszr_cmd_t rd_data,
    output logic       empty
);

    `include "pvs_zero_run_decoder_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

    pvszr_cmd_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `PVSZR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_C)
    `PVSZR_ASSERT_NEXT(a_count_up, clk, rst_n, do_wr && !do_rd,
                       count_reg == $past(count_reg) + 1'b1)
    `PVSZR_ASSERT_NEXT(a_count_down, clk, rst_n, do_rd && !do_wr,
                       count_reg == $past(count_reg) - 1'b1)

endmodule

// ----- sv/pvszr_back.sv -----
// Result sequencer: expands each command into leaf results, one per cycle while they are popped.
`timescale 1ns / 1ps

module pvszr_back
    import pvszr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pvszr_cmd_t         cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output logic [INDEX_W-1:0] leaf_index,
    output logic               leaf_valid,
    output logic               last,
    output logic               row_done,
    output logic               empty,
    input  logic               pop
);

    `include "pvs_zero_run_decoder_macros.svh"

    localparam int POS_W = $clog2(BITS_PER_BYTE);

    logic [BITS_PER_BYTE-1:0] used_reg;
    logic [BITS_PER_BYTE-1:0] used_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [INDEX_W-1:0]       out_index_reg;
    logic                     out_leaf_reg;
    logic                     out_last_reg;
    logic                     out_done_reg;

    logic [BITS_PER_BYTE-1:0] work;
    logic [BITS_PER_BYTE-1:0] lowbit;
    logic [BITS_PER_BYTE-1:0] rest;
    logic [POS_W-1:0]         pos;
    logic                     pop_beat;
    logic                     can_load;
    logic                     emit;
    logic                     is_last;
    logic                     has_leaf;

    always_comb
    begin
        work   = cmd.mask & ~used_reg;
        lowbit = work & (~work + 1'b1);
        rest   = work & ~lowbit;
        pos    = '0;
        for (int i = BITS_PER_BYTE - 1; i >= 0; i--)
        begin
            if (work[i])
            begin
                pos = POS_W'(i);
            end
        end
    end

    assign has_leaf = (cmd.mask != '0);
    assign pop_beat = pop && out_valid_reg;
    assign can_load = !out_valid_reg || pop_beat;
    assign emit     = can_load && !cmd_empty;
    assign is_last  = !has_leaf || (rest == '0);
    assign cmd_pop  = emit && is_last;

    always_comb
    begin
        used_next      = used_reg;
        out_valid_next = out_valid_reg;
        if (pop_beat)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            used_next      = is_last ? '0 : (used_reg | lowbit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_index_reg <= has_leaf ? (cmd.base + INDEX_W'(pos)) : '0;
            out_leaf_reg  <= has_leaf;
            out_last_reg  <= is_last;
            out_done_reg  <= cmd.done;
        end
    end

    assign empty      = !out_valid_reg;
    assign leaf_index = out_index_reg;
    assign leaf_valid = out_leaf_reg;
    assign last       = out_last_reg;
    assign row_done   = out_done_reg;

    `PVSZR_ASSERT_NEXT(a_used_clear, clk, rst_n, cmd_pop, used_reg == '0)
    `PVSZR_ASSERT_NOW(a_emit_bit, clk, rst_n, emit && has_leaf, lowbit != '0)
    `PVSZR_ASSERT_NOW(a_used_subset, clk, rst_n, !cmd_empty,
                      (used_reg & ~cmd.mask) == '0)

endmodule

// ----- test/pvs_zero_run_decoder_checker.sv -----
// Checker that predicts the leaf beats of the zero-run visibility decoder and compares them.
`timescale 1ns / 1ps

module pvs_zero_run_decoder_checker
    import pvszr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    input  logic               push,
    input  logic               full,
    input  logic [7:0]         pvs_byte,
    input  logic               row_start,
    input  logic               empty,
    input  logic               pop,
    input  logic [INDEX_W-1:0] leaf_index,
    input  logic               leaf_valid,
    input  logic               last,
    input  logic               row_done,
    output int                 fail_count,
    output int                 beats_left
);

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               valid;
        logic               last;
        logic               done;
    } leaf_beat_t;

    leaf_beat_t         leaf_beats_q[$];
    leaf_beat_t         want_beat;
    leaf_beat_t         got_beat;
    logic [COUNT_W-1:0] leaf_count;
    int                 leaf_pos;
    bit                 zero_seen;
    int                 n_fail;

    function automatic void add_beat(input int idx, input bit valid, input bit lst,
                                     input bit done);
        leaf_beat_t beat;
        beat.index = idx[INDEX_W-1:0];
        beat.valid = valid;
        beat.last  = lst;
        beat.done  = done;
        leaf_beats_q.insert(leaf_beats_q.size(), beat);
    endfunction

    function automatic void decode_byte(input logic [7:0] vis, input logic start);
        int lim;
        int hits[BITS_PER_BYTE];
        int n;
        int i;
        bit done;
        lim = (leaf_count > MAX_LEAVES) ? MAX_LEAVES : int'(leaf_count);
        n = 0;
        if (start)
        begin
            leaf_pos  = 0;
            zero_seen = 1'b0;
        end
        if (leaf_pos >= lim)
        begin
            zero_seen = 1'b0;
            add_beat(0, 1'b0, 1'b1, 1'b1);
            return;
        end
        if (zero_seen)
        begin
            leaf_pos  = leaf_pos + int'(vis) * BITS_PER_BYTE;
            if (leaf_pos > lim)
                leaf_pos = lim;
            zero_seen = 1'b0;
        end
        else if (vis == 8'h00)
        begin
            zero_seen = 1'b1;
        end
        else
        begin
            for (i = 0; i < BITS_PER_BYTE; i++)
            begin
                if (vis[i] && (leaf_pos + i < lim))
                begin
                    hits[n] = leaf_pos + i;
                    n++;
                end
            end
            leaf_pos = leaf_pos + BITS_PER_BYTE;
            if (leaf_pos > lim)
                leaf_pos = lim;
        end
        done = (leaf_pos >= lim);
        if (n == 0)
            add_beat(0, 1'b0, 1'b1, done);
        else
            for (i = 0; i < n; i++)
                add_beat(hits[i], 1'b1, (i == n - 1), done);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_beats_q.delete();
            leaf_count = '0;
            leaf_pos   = 0;
            zero_seen  = 1'b0;
            n_fail     = 0;
            fail_count <= 0;
            beats_left <= 0;
        end
        else
        begin
            if (cfg_we)
                leaf_count = cfg_wdata;
            if (pop && !empty)
            begin
                got_beat = '{leaf_index, leaf_valid, last, row_done};
                if (leaf_beats_q.size() == 0)
                begin
                    if (n_fail < 10)
                        $display("unexpected beat: index %0d valid %0b last %0b done %0b",
                                 leaf_index, leaf_valid, last, row_done);
                    n_fail++;
                end
                else
                begin
                    want_beat = leaf_beats_q.pop_front();
                    if (got_beat !== want_beat)
                    begin
                        if (n_fail < 10)
                            $display("mismatch: expected %0d %0b %0b %0b, got %0d %0b %0b %0b",
                                     want_beat.index, want_beat.valid, want_beat.last,
                                     want_beat.done, leaf_index, leaf_valid, last, row_done);
                        n_fail++;
                    end
                end
            end
            if (push && !full)
                decode_byte(pvs_byte, row_start);
            fail_count <= n_fail;
            beats_left <= leaf_beats_q.size();
        end
    end

endmodule

// ----- test/tb_pvs_zero_run_decoder.sv -----
// Testbench top of the zero-run visibility decoder: drives bytes and leaf counts, gives the verdict.
`timescale 1ns / 1ps

module tb_pvs_zero_run_decoder;
    import pvszr_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;
    logic               push;
    logic               full;
    logic [7:0]         pvs_byte;
    logic               row_start;
    logic               empty;
    logic               pop;
    logic [INDEX_W-1:0] leaf_index;
    logic               leaf_valid;
    logic               last;
    logic               row_done;
    int                 fail_count;
    int                 beats_left;
    int                 stall_cycles = 0;
    int                 bytes_sent = 0;
    bit                 no_idle = 1'b0;

    always #5 clk = ~clk;

    pvs_zero_run_decoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .pvs_byte   (pvs_byte),
        .row_start  (row_start),
        .empty      (empty),
        .pop        (pop),
        .leaf_index (leaf_index),
        .leaf_valid (leaf_valid),
        .last       (last),
        .row_done   (row_done)
    );

    pvs_zero_run_decoder_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .pvs_byte   (pvs_byte),
        .row_start  (row_start),
        .empty      (empty),
        .pop        (pop),
        .leaf_index (leaf_index),
        .leaf_valid (leaf_valid),
        .last       (last),
        .row_done   (row_done),
        .fail_count (fail_count),
        .beats_left (beats_left)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_run();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(0, 6);
        return $urandom_range(0, 255);
    endfunction

    task automatic send_byte(input logic [7:0] vis, input logic start);
        int g;
        g = no_idle ? 0 : pick_gap();
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
        push      <= 1'b1;
        pvs_byte  <= vis;
        row_start <= start;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (beats_left != 0)
            @(posedge clk);
    endtask

    task automatic set_leaf_count(input int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[COUNT_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_row(input int n_bytes);
        int k;
        int r;
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        for (k = 1; k < n_bytes; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 18)
            begin
                send_byte(8'h00, 1'b0);
                send_byte(8'(pick_run()), 1'b0);
            end
            else if (r < 24)
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                send_byte(8'($urandom_range(1, 255)), 1'b0);
        end
    endtask

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : result_drain
        int g;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (no_idle)
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                g = pick_gap();
                if (g > 0)
                begin
                    pop <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                pop <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int limits[7];
        int phase;
        int phase_end;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        push      <= 1'b0;
        pvs_byte  <= 8'h00;
        row_start <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A leaf count of zero leaves every row complete from its start.
        send_byte(8'hFF, 1'b1);

        set_leaf_count(20);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h0F, 1'b1);

        set_leaf_count(MAX_LEAVES);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h05, 1'b0);

        // Lowering the leaf count mid-row leaves the counter past the new end.
        set_leaf_count(16);
        send_byte(8'hFF, 1'b0);

        set_leaf_count(1);
        send_byte(8'hFF, 1'b1);

        limits[0] = 8;
        limits[1] = MAX_LEAVES;
        limits[2] = $urandom_range(9, 64);
        limits[3] = 0;
        limits[4] = $urandom_range(65, MAX_LEAVES);
        limits[5] = 1;
        limits[6] = 24;
        for (phase = 0; phase < 7; phase++)
        begin
            set_leaf_count(limits[phase]);
            no_idle   = (phase == 2);
            phase_end = bytes_sent + 18;
            while (bytes_sent < phase_end)
            begin
                random_row($urandom_range(2, 12));
                if (phase == 4 && bytes_sent > phase_end - 13 && bytes_sent < phase_end - 6)
                    drain();
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && beats_left == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
